FILE: rtl/core/cdt_pkg.sv
// cdt_pkg: types, codes and microprogram of the calendar date and time adder
// no dependencies; used by the top level and the testbench
`default_nettype none

package cdt_pkg;

  typedef enum logic [2:0] {
    MODE_RESTART = 3'd0,
    MODE_SECONDS = 3'd1,
    MODE_MINUTES = 3'd2,
    MODE_HOURS   = 3'd3,
    MODE_DAYS    = 3'd4,
    MODE_MONTHS  = 3'd5,
    MODE_YEARS   = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_NEG  = 2'd1,
    ERR_SAT  = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    CFG_START_DAY    = 3'd0,
    CFG_START_MONTH  = 3'd1,
    CFG_START_YEAR   = 3'd2,
    CFG_START_HOUR   = 3'd3,
    CFG_START_MINUTE = 3'd4,
    CFG_START_SECOND = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_ERR,
    OP_ADD,
    OP_DIV,
    OP_REM,
    OP_WALK,
    OP_YADD,
    OP_DONE
  } op_t;

  typedef enum logic [2:0] {
    U_ZERO,
    U_SEC,
    U_MIN,
    U_HOUR,
    U_DAY,
    U_MON,
    U_YMOD,
    U_NMOD
  } unit_t;

  typedef enum logic {
    B_AMT,
    B_QUO
  } src_t;

  typedef enum logic [1:0] {
    D60,
    D24,
    D12,
    D400
  } dsel_t;

  typedef enum logic [1:0] {
    C_NEXT,
    C_ALWAYS,
    C_MORE
  } cond_t;

  typedef logic [4:0] pc_t;

  typedef struct packed {
    op_t   op;
    unit_t unit;
    src_t  src;
    dsel_t dsel;
    cond_t cond;
    pc_t   target;
  } uword_t;

  localparam pc_t A_LOAD       = 5'd0;
  localparam pc_t A_LOAD_DIV   = 5'd1;
  localparam pc_t A_LOAD_REM   = 5'd2;
  localparam pc_t A_REJECT     = 5'd3;
  localparam pc_t A_SEC        = 5'd4;
  localparam pc_t A_SEC_DIV    = 5'd5;
  localparam pc_t A_SEC_REM    = 5'd6;
  localparam pc_t A_SEC_CARRY  = 5'd7;
  localparam pc_t A_MIN        = 5'd8;
  localparam pc_t A_MIN_DIV    = 5'd9;
  localparam pc_t A_MIN_REM    = 5'd10;
  localparam pc_t A_MIN_CARRY  = 5'd11;
  localparam pc_t A_HOUR       = 5'd12;
  localparam pc_t A_HOUR_DIV   = 5'd13;
  localparam pc_t A_HOUR_REM   = 5'd14;
  localparam pc_t A_HOUR_CARRY = 5'd15;
  localparam pc_t A_DAY        = 5'd16;
  localparam pc_t A_WALK       = 5'd17;
  localparam pc_t A_DONE       = 5'd18;
  localparam pc_t A_MON        = 5'd19;
  localparam pc_t A_MON_DIV    = 5'd20;
  localparam pc_t A_MON_REM    = 5'd21;
  localparam pc_t A_MON_YDIV   = 5'd22;
  localparam pc_t A_MON_YREM   = 5'd23;
  localparam pc_t A_MON_YADD   = 5'd24;
  localparam pc_t A_YEAR       = 5'd25;
  localparam pc_t A_YEAR_DIV   = 5'd26;
  localparam pc_t A_YEAR_REM   = 5'd27;
  localparam pc_t A_YEAR_ADD   = 5'd28;

  localparam int AMT_W  = 15;
  localparam int ACC_W  = 16;
  localparam int QUO_W  = 12;
  localparam int RCP_W  = 17;
  localparam int PROD_W = ACC_W + RCP_W;

  function automatic uword_t uw(op_t op, unit_t unit, src_t src, dsel_t dsel,
                                cond_t cond, pc_t target);
    uword_t w;
    w.op     = op;
    w.unit   = unit;
    w.src    = src;
    w.dsel   = dsel;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  function automatic uword_t ucode(pc_t a);
    uword_t w;
    w = uw(OP_DONE, U_ZERO, B_AMT, D60, C_ALWAYS, A_DONE);
    unique case (a)
      A_LOAD:       w = uw(OP_LOAD, U_ZERO, B_AMT, D400, C_NEXT,   A_DONE);
      A_LOAD_DIV:   w = uw(OP_DIV,  U_ZERO, B_AMT, D400, C_NEXT,   A_DONE);
      A_LOAD_REM:   w = uw(OP_REM,  U_YMOD, B_AMT, D400, C_ALWAYS, A_DONE);
      A_REJECT:     w = uw(OP_ERR,  U_ZERO, B_AMT, D60,  C_ALWAYS, A_DONE);
      A_SEC:        w = uw(OP_ADD,  U_SEC,  B_AMT, D60,  C_NEXT,   A_DONE);
      A_SEC_DIV:    w = uw(OP_DIV,  U_ZERO, B_AMT, D60,  C_NEXT,   A_DONE);
      A_SEC_REM:    w = uw(OP_REM,  U_SEC,  B_AMT, D60,  C_NEXT,   A_DONE);
      A_SEC_CARRY:  w = uw(OP_ADD,  U_MIN,  B_QUO, D60,  C_ALWAYS, A_MIN_DIV);
      A_MIN:        w = uw(OP_ADD,  U_MIN,  B_AMT, D60,  C_NEXT,   A_DONE);
      A_MIN_DIV:    w = uw(OP_DIV,  U_ZERO, B_AMT, D60,  C_NEXT,   A_DONE);
      A_MIN_REM:    w = uw(OP_REM,  U_MIN,  B_AMT, D60,  C_NEXT,   A_DONE);
      A_MIN_CARRY:  w = uw(OP_ADD,  U_HOUR, B_QUO, D24,  C_ALWAYS, A_HOUR_DIV);
      A_HOUR:       w = uw(OP_ADD,  U_HOUR, B_AMT, D24,  C_NEXT,   A_DONE);
      A_HOUR_DIV:   w = uw(OP_DIV,  U_ZERO, B_AMT, D24,  C_NEXT,   A_DONE);
      A_HOUR_REM:   w = uw(OP_REM,  U_HOUR, B_AMT, D24,  C_NEXT,   A_DONE);
      A_HOUR_CARRY: w = uw(OP_ADD,  U_DAY,  B_QUO, D24,  C_ALWAYS, A_WALK);
      A_DAY:        w = uw(OP_ADD,  U_DAY,  B_AMT, D60,  C_NEXT,   A_DONE);
      A_WALK:       w = uw(OP_WALK, U_ZERO, B_AMT, D60,  C_MORE,   A_WALK);
      A_DONE:       w = uw(OP_DONE, U_ZERO, B_AMT, D60,  C_ALWAYS, A_DONE);
      A_MON:        w = uw(OP_ADD,  U_MON,  B_AMT, D12,  C_NEXT,   A_DONE);
      A_MON_DIV:    w = uw(OP_DIV,  U_ZERO, B_AMT, D12,  C_NEXT,   A_DONE);
      A_MON_REM:    w = uw(OP_REM,  U_MON,  B_AMT, D12,  C_NEXT,   A_DONE);
      A_MON_YDIV:   w = uw(OP_DIV,  U_ZERO, B_AMT, D400, C_NEXT,   A_DONE);
      A_MON_YREM:   w = uw(OP_REM,  U_NMOD, B_AMT, D400, C_NEXT,   A_DONE);
      A_MON_YADD:   w = uw(OP_YADD, U_MON,  B_AMT, D400, C_ALWAYS, A_DONE);
      A_YEAR:       w = uw(OP_ADD,  U_ZERO, B_AMT, D400, C_NEXT,   A_DONE);
      A_YEAR_DIV:   w = uw(OP_DIV,  U_ZERO, B_AMT, D400, C_NEXT,   A_DONE);
      A_YEAR_REM:   w = uw(OP_REM,  U_NMOD, B_AMT, D400, C_NEXT,   A_DONE);
      A_YEAR_ADD:   w = uw(OP_YADD, U_ZERO, B_AMT, D400, C_ALWAYS, A_DONE);
      default: ;
    endcase
    return w;
  endfunction

  function automatic pc_t entry(logic [2:0] mode, logic neg);
    pc_t a;
    unique case (mode)
      MODE_RESTART: a = A_LOAD;
      MODE_SECONDS: a = A_SEC;
      MODE_MINUTES: a = A_MIN;
      MODE_HOURS:   a = A_HOUR;
      MODE_DAYS:    a = A_DAY;
      MODE_MONTHS:  a = A_MON;
      MODE_YEARS:   a = A_YEAR;
      default:      a = A_DONE;
    endcase
    if (neg && a != A_LOAD && a != A_DONE) begin
      a = A_REJECT;
    end
    return a;
  endfunction

  // reciprocal and shift chosen so that the quotient is exact below 2^16
  function automatic logic [RCP_W-1:0] recip(dsel_t d);
    logic [RCP_W-1:0] r;
    unique case (d)
      D60:  r = 17'd34953;
      D24:  r = 17'd43691;
      D12:  r = 17'd43691;
      D400: r = 17'd83887;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] divisor(dsel_t d);
    logic [8:0] v;
    unique case (d)
      D60:  v = 9'd60;
      D24:  v = 9'd24;
      D12:  v = 9'd12;
      D400: v = 9'd400;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  function automatic logic [QUO_W-1:0] quotient(logic [PROD_W-1:0] p, dsel_t d);
    logic [QUO_W-1:0] q;
    unique case (d)
      D60:  q = p[32:21];
      D24:  q = p[31:20];
      D12:  q = p[30:19];
      D400: q = {4'b0, p[32:25]};
      default: q = '0;
    endcase
    return q;
  endfunction

  // year held modulo 400 decides the leap rule
  function automatic logic is_leap(logic [8:0] ymod);
    return (ymod[1:0] == 2'd0) && (ymod != 9'd100) && (ymod != 9'd200)
           && (ymod != 9'd300);
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] month, logic leap);
    logic [4:0] len;
    unique case (month)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cdt_in_if.sv
// cdt_in_if: request channel carrying mode and amount
// depends on nothing
`default_nettype none

interface cdt_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic signed [15:0] amount;

  modport source (output valid, output mode, output amount, input ready);
  modport sink (input valid, input mode, input amount, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/cdt_out_if.sv
// cdt_out_if: result channel carrying date, time, validity and error code
// depends on nothing
`default_nettype none

interface cdt_out_if #(
  parameter int YEAR_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [4:0]           day_out;
  logic [3:0]           month_out;
  logic [YEAR_BITS-1:0] year_out;
  logic [4:0]           hour_out;
  logic [5:0]           minute_out;
  logic [5:0]           second_out;
  logic                 date_valid;
  logic [1:0]           error;

  modport source (output valid, output day_out, output month_out, output year_out,
                  output hour_out, output minute_out, output second_out,
                  output date_valid, output error, input ready);
  modport sink (input valid, input day_out, input month_out, input year_out,
                input hour_out, input minute_out, input second_out,
                input date_valid, input error, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/calendar_datetime_adder.sv
// calendar_datetime_adder: microcoded date and time adder, one result per request
// depends on cdt_pkg, cdt_in_if and cdt_out_if
// requests: one at a time, the next taken once the last result is registered; the day walk crosses one month per step
// reset: synchronous; date 1/1/0, time 00:00:00, start registers to the same
`default_nettype none

module calendar_datetime_adder #(
  parameter int YEAR_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  wire logic [2:0]  wr_index,
  input  wire logic [15:0] wr_data,
  cdt_in_if.sink           item,
  cdt_out_if.source        result
);

  localparam int SUM_W = ((YEAR_BITS > cdt_pkg::ACC_W) ? YEAR_BITS : cdt_pkg::ACC_W) + 1;
  localparam logic [YEAR_BITS-1:0] YEAR_MAX = '1;
  localparam longint unsigned YEAR_TOP = (64'd1 << YEAR_BITS) - 64'd1;
  localparam logic [8:0] YMAX_MOD = 9'(YEAR_TOP % 64'd400);

  logic [4:0]  start_day;
  logic [3:0]  start_month;
  logic [15:0] start_year;
  logic [4:0]  start_hour;
  logic [5:0]  start_minute;
  logic [5:0]  start_second;

  logic [4:0]           day;
  logic [3:0]           month;
  logic [YEAR_BITS-1:0] year;
  logic [4:0]           hour;
  logic [5:0]           minute;
  logic [5:0]           second;
  logic [8:0]           ymod;
  cdt_pkg::err_t        err;

  logic [cdt_pkg::AMT_W-1:0] amt;
  logic [cdt_pkg::ACC_W-1:0] acc;
  logic [cdt_pkg::QUO_W-1:0] quo;
  logic [3:0]                mrem;
  logic [9:0]                ytmp;

  logic           busy, busy_next;
  cdt_pkg::pc_t   pc, pc_next;
  cdt_pkg::uword_t uw;

  logic                       accept, out_free, done_fire;
  logic                       leap, fit, more;
  logic [4:0]                 len;
  logic [5:0]                 unit_val;
  logic [cdt_pkg::ACC_W-1:0]  add_b;
  logic [cdt_pkg::PROD_W-1:0] prod;
  logic [cdt_pkg::QUO_W-1:0]  q_new;
  logic [cdt_pkg::ACC_W-1:0]  rem;
  logic [SUM_W-1:0]           ysum;
  logic                       yovf;
  logic [YEAR_BITS-1:0]       year_load;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      start_day    <= 5'd1;
      start_month  <= 4'd1;
      start_year   <= '0;
      start_hour   <= '0;
      start_minute <= '0;
      start_second <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        cdt_pkg::CFG_START_DAY:    start_day    <= wr_data[4:0];
        cdt_pkg::CFG_START_MONTH:  start_month  <= wr_data[3:0];
        cdt_pkg::CFG_START_YEAR:   start_year   <= wr_data;
        cdt_pkg::CFG_START_HOUR:   start_hour   <= wr_data[4:0];
        cdt_pkg::CFG_START_MINUTE: start_minute <= wr_data[5:0];
        cdt_pkg::CFG_START_SECOND: start_second <= wr_data[5:0];
        default: ;
      endcase
    end
  end

  // sequencer
  assign uw        = cdt_pkg::ucode(pc);
  assign item.ready = !busy && !rst;
  assign accept    = item.valid && item.ready;
  assign out_free  = !result.valid || result.ready;
  assign done_fire = busy && (uw.op == cdt_pkg::OP_DONE) && out_free;

  always_comb begin
    busy_next = busy;
    pc_next   = pc;
    if (!busy) begin
      if (accept) begin
        busy_next = 1'b1;
        pc_next   = cdt_pkg::entry(item.mode, item.amount[15]);
      end
    end else if (uw.op == cdt_pkg::OP_DONE) begin
      if (out_free) begin
        busy_next = 1'b0;
      end
    end else begin
      unique case (uw.cond)
        cdt_pkg::C_NEXT:   pc_next = pc + 5'd1;
        cdt_pkg::C_ALWAYS: pc_next = uw.target;
        cdt_pkg::C_MORE:   pc_next = more ? uw.target : pc + 5'd1;
        default:           pc_next = pc + 5'd1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= cdt_pkg::A_DONE;
    end else begin
      busy <= busy_next;
      pc   <= pc_next;
    end
  end

  // datapath
  assign leap      = cdt_pkg::is_leap(ymod);
  assign len       = cdt_pkg::month_len(month, leap);
  assign fit       = acc <= {11'b0, len};
  assign more      = !fit && !((month == 4'd12) && (year == YEAR_MAX));
  assign year_load = YEAR_BITS'(start_year);
  assign prod      = {17'b0, acc} * {16'b0, cdt_pkg::recip(uw.dsel)};
  assign q_new     = cdt_pkg::quotient(prod, uw.dsel);
  assign rem       = acc - ({4'b0, quo} * {7'b0, cdt_pkg::divisor(uw.dsel)});
  assign ysum      = SUM_W'(year) + SUM_W'(acc);
  assign yovf      = |ysum[SUM_W-1:YEAR_BITS];
  assign add_b     = (uw.src == cdt_pkg::B_QUO) ? {4'b0, quo} : {1'b0, amt};

  always_comb begin
    unique case (uw.unit)
      cdt_pkg::U_SEC:  unit_val = second;
      cdt_pkg::U_MIN:  unit_val = minute;
      cdt_pkg::U_HOUR: unit_val = {1'b0, hour};
      cdt_pkg::U_DAY:  unit_val = {1'b0, day};
      cdt_pkg::U_MON:  unit_val = {2'b0, month - 4'd1};
      default:         unit_val = '0;
    endcase
  end

  // scratch registers
  always_ff @(posedge clk) begin
    if (accept) begin
      amt <= item.amount[14:0];
    end
    if (busy) begin
      unique case (uw.op)
        cdt_pkg::OP_LOAD: acc <= 16'(year_load);
        cdt_pkg::OP_ADD:  acc <= {10'b0, unit_val} + add_b;
        cdt_pkg::OP_DIV:  quo <= q_new;
        cdt_pkg::OP_REM: begin
          if (uw.unit == cdt_pkg::U_MON) begin
            mrem <= rem[3:0];
            acc  <= {4'b0, quo};
          end
          if (uw.unit == cdt_pkg::U_NMOD) begin
            ytmp <= {1'b0, ymod} + {1'b0, rem[8:0]};
          end
        end
        cdt_pkg::OP_WALK: begin
          if (!fit) begin
            acc <= acc - {11'b0, len};
          end
        end
        default: ;
      endcase
    end
  end

  // date and time state
  always_ff @(posedge clk) begin
    if (rst) begin
      day    <= 5'd1;
      month  <= 4'd1;
      year   <= '0;
      hour   <= '0;
      minute <= '0;
      second <= '0;
      ymod   <= '0;
      err    <= cdt_pkg::ERR_NONE;
    end else begin
      if (accept) begin
        err <= cdt_pkg::ERR_NONE;
      end
      if (busy) begin
        unique case (uw.op)
          cdt_pkg::OP_LOAD: begin
            day    <= (start_day == 5'd0) ? 5'd1 : start_day;
            month  <= (start_month == 4'd0) ? 4'd1 :
                      (start_month > 4'd12) ? 4'd12 : start_month;
            year   <= year_load;
            hour   <= (start_hour > 5'd23) ? 5'd23 : start_hour;
            minute <= (start_minute > 6'd59) ? 6'd59 : start_minute;
            second <= (start_second > 6'd59) ? 6'd59 : start_second;
          end
          cdt_pkg::OP_ERR: err <= cdt_pkg::ERR_NEG;
          cdt_pkg::OP_REM: begin
            unique case (uw.unit)
              cdt_pkg::U_SEC:  second <= rem[5:0];
              cdt_pkg::U_MIN:  minute <= rem[5:0];
              cdt_pkg::U_HOUR: hour   <= rem[4:0];
              cdt_pkg::U_YMOD: ymod   <= rem[8:0];
              default: ;
            endcase
          end
          cdt_pkg::OP_WALK: begin
            if (fit) begin
              day <= acc[4:0];
            end else if (month != 4'd12) begin
              month <= month + 4'd1;
            end else if (year == YEAR_MAX) begin
              day <= 5'd31;
              err <= cdt_pkg::ERR_SAT;
            end else begin
              month <= 4'd1;
              year  <= year + YEAR_BITS'(1);
              ymod  <= (ymod == 9'd399) ? 9'd0 : ymod + 9'd1;
            end
          end
          cdt_pkg::OP_YADD: begin
            if (yovf) begin
              year  <= YEAR_MAX;
              month <= 4'd12;
              day   <= 5'd31;
              ymod  <= YMAX_MOD;
              err   <= cdt_pkg::ERR_SAT;
            end else begin
              year <= ysum[YEAR_BITS-1:0];
              ymod <= (ytmp >= 10'd400) ? 9'(ytmp - 10'd400) : ytmp[8:0];
              if (uw.unit == cdt_pkg::U_MON) begin
                month <= mrem + 4'd1;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (done_fire) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      result.day_out    <= day;
      result.month_out  <= month;
      result.year_out   <= year;
      result.hour_out   <= hour;
      result.minute_out <= minute;
      result.second_out <= second;
      result.date_valid <= (day != 5'd0) && (day <= len);
      result.error      <= err;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("request taken but sequencer not started");

  a_done_result: assert property (@(posedge clk) disable iff (rst)
    done_fire |=> result.valid && !busy)
    else $error("finished step did not register a result");

  a_walk_sane: assert property (@(posedge clk) disable iff (rst)
    busy && (uw.op == cdt_pkg::OP_WALK) |-> acc != '0 && ymod < 9'd400
      && month != 4'd0 && month <= 4'd12)
    else $error("day walk entered with bad operands");

  a_ymod_sum: assert property (@(posedge clk) disable iff (rst)
    busy && (uw.op == cdt_pkg::OP_YADD) |-> ytmp < 10'd800)
    else $error("year residue out of range");

endmodule

`default_nettype wire

FILE: tb/cdt_checker.sv
`timescale 1ns / 1ps
// cdt_checker: follows the start register writes and both channels of calendar_datetime_adder,
// keeps its own date and time, predicts every result and compares it with what comes out
// depends on cdt_pkg, cdt_in_if and cdt_out_if
module cdt_checker
  import cdt_pkg::*;
#(
  parameter int YEAR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [15:0] wr_data,
  cdt_in_if           item,
  cdt_out_if          result,
  output int unsigned failures,
  output int unsigned backlog
);

  localparam longint unsigned YEAR_TOP = (longint'(1) << YEAR_BITS) - 1;

  typedef struct packed {
    logic [4:0]           day;
    logic [3:0]           month;
    logic [YEAR_BITS-1:0] year;
    logic [4:0]           hour;
    logic [5:0]           minute;
    logic [5:0]           second;
    logic                 date_ok;
    err_t                 code;
  } stamp_t;

  logic [4:0]  start_day, start_hour;
  logic [3:0]  start_month;
  logic [15:0] start_year;
  logic [5:0]  start_minute, start_second;

  longint unsigned cal_day, cal_month, cal_year;
  longint unsigned tod_hour, tod_minute, tod_second;
  err_t            status;

  stamp_t      pending_stamps[$];
  int unsigned fault_count = 0;

  assign failures = fault_count;

  function automatic bit leap_year(longint unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint unsigned days_in_month(longint unsigned m, longint unsigned y);
    if (m == 2) return leap_year(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic longint unsigned limit_to(longint unsigned v, longint unsigned lo,
                                               longint unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // past the top year the date sticks at the last day of that year
  function automatic bit bump_years(longint unsigned n);
    if (n > YEAR_TOP - cal_year) begin
      cal_year  = YEAR_TOP;
      cal_month = 12;
      cal_day   = 31;
      status    = ERR_SAT;
      return 1'b0;
    end
    cal_year += n;
    return 1'b1;
  endfunction

  function automatic void walk_days(longint unsigned n);
    longint unsigned t;
    t = cal_day + n;
    while (t > days_in_month(cal_month, cal_year)) begin
      t -= days_in_month(cal_month, cal_year);
      if (cal_month >= 12) begin
        cal_month = 1;
        if (!bump_years(1)) return;
      end else begin
        cal_month++;
      end
    end
    cal_day = t;
  endfunction

  function automatic stamp_t advance_clock(logic [2:0] op, logic [15:0] amt);
    longint unsigned v, t, carry;
    stamp_t s;
    v = amt;
    carry = 0;
    status = ERR_NONE;
    if (op == MODE_RESTART) begin
      cal_day    = limit_to(start_day, 1, 31);
      cal_month  = limit_to(start_month, 1, 12);
      cal_year   = start_year & YEAR_TOP;
      tod_hour   = limit_to(start_hour, 0, 23);
      tod_minute = limit_to(start_minute, 0, 59);
      tod_second = limit_to(start_second, 0, 59);
    end else if (op <= MODE_YEARS && amt[15]) begin
      status = ERR_NEG;
    end else if (op >= MODE_SECONDS && op <= MODE_DAYS) begin
      if (op == MODE_DAYS) begin
        carry = v;
      end else begin
        if (op == MODE_SECONDS) begin
          t = tod_second + v;
          tod_second = t % 60;
          v = t / 60;
        end
        if (op <= MODE_MINUTES) begin
          t = tod_minute + v;
          tod_minute = t % 60;
          v = t / 60;
        end
        t = tod_hour + v;
        tod_hour = t % 24;
        carry = t / 24;
      end
      // the walk runs even without a carry, so an ill-fitting day rolls over
      walk_days(carry);
    end else if (op == MODE_MONTHS) begin
      t = cal_month - 1 + v;
      if (bump_years(t / 12)) cal_month = t % 12 + 1;
    end else if (op == MODE_YEARS) begin
      void'(bump_years(v));
    end
    s.day     = cal_day[4:0];
    s.month   = cal_month[3:0];
    s.year    = cal_year[YEAR_BITS-1:0];
    s.hour    = tod_hour[4:0];
    s.minute  = tod_minute[5:0];
    s.second  = tod_second[5:0];
    s.date_ok = (cal_day >= 1) && (cal_day <= days_in_month(cal_month, cal_year));
    s.code    = status;
    return s;
  endfunction

  function automatic string show(stamp_t s);
    return $sformatf("%0d-%0d-%0d %0d:%0d:%0d valid %0d error %0d", s.year, s.month, s.day,
                     s.hour, s.minute, s.second, s.date_ok, s.code);
  endfunction

  task automatic log_fault(string what);
    fault_count++;
    if (fault_count <= 10) $display("%s", what);
  endtask

  always @(posedge clk) begin
    stamp_t seen, want;
    if (rst) begin
      start_day    = 5'd1;
      start_month  = 4'd1;
      start_year   = '0;
      start_hour   = '0;
      start_minute = '0;
      start_second = '0;
      cal_day      = 1;
      cal_month    = 1;
      cal_year     = 0;
      tod_hour     = 0;
      tod_minute   = 0;
      tod_second   = 0;
      pending_stamps.delete();
      backlog <= 0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          CFG_START_DAY:    start_day    = wr_data[4:0];
          CFG_START_MONTH:  start_month  = wr_data[3:0];
          CFG_START_YEAR:   start_year   = wr_data;
          CFG_START_HOUR:   start_hour   = wr_data[4:0];
          CFG_START_MINUTE: start_minute = wr_data[5:0];
          CFG_START_SECOND: start_second = wr_data[5:0];
          default: ;
        endcase
      end
      if (item.valid && item.ready) begin
        pending_stamps.push_back(advance_clock(item.mode, item.amount));
      end
      if (result.valid && result.ready) begin
        seen.day     = result.day_out;
        seen.month   = result.month_out;
        seen.year    = result.year_out;
        seen.hour    = result.hour_out;
        seen.minute  = result.minute_out;
        seen.second  = result.second_out;
        seen.date_ok = result.date_valid;
        seen.code    = err_t'(result.error);
        if (pending_stamps.size() == 0) begin
          log_fault($sformatf("unexpected result: got %s", show(seen)));
        end else begin
          want = pending_stamps.pop_front();
          if (seen !== want) begin
            log_fault($sformatf("mismatch: expected %s, got %s", show(want), show(seen)));
          end
        end
      end
      backlog <= pending_stamps.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: clock, reset, start register writes, request stimulus and result back-pressure
// for calendar_datetime_adder; the verdict comes from the failure count and backlog of cdt_checker and a stall watchdog
// depends on cdt_pkg, cdt_in_if, cdt_out_if, calendar_datetime_adder and cdt_checker
module tb_top;
  import cdt_pkg::*;

  localparam int         YEAR_BITS      = 16;
  localparam logic [2:0] MODE_SPARE     = 3'd7;
  localparam int         MAX_IDLE       = 11;
  localparam int         STALL_LIMIT    = 6000;
  localparam int         RANDOM_PHASES  = 12;
  localparam int         PHASE_REQUESTS = 43;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        wr_en    = 1'b0;
  logic [2:0]  wr_index = '0;
  logic [15:0] wr_data  = '0;
  logic [15:0] start_words [6];
  bit          calm = 1'b0;
  int unsigned failures, backlog;
  int unsigned quiet_cycles = 0;

  cdt_in_if                           item_ch ();
  cdt_out_if #(.YEAR_BITS(YEAR_BITS)) result_ch ();

  calendar_datetime_adder #(.YEAR_BITS(YEAR_BITS)) DUT (
    .clk, .rst, .wr_en, .wr_index, .wr_data,
    .item(item_ch),
    .result(result_ch)
  );

  cdt_checker #(.YEAR_BITS(YEAR_BITS)) u_checker (
    .clk, .rst, .wr_en, .wr_index, .wr_data,
    .item(item_ch),
    .result(result_ch),
    .failures(failures),
    .backlog(backlog)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int idle_draw();
    return calm ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  task automatic send_request(logic [2:0] op, logic [15:0] amt);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid  <= 1'b1;
    item_ch.mode   <= op;
    item_ch.amount <= amt;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  task automatic settle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    calm = ($urandom_range(0, 3) == 0);
  endtask

  task automatic load_start();
    for (int i = CFG_START_DAY; i <= CFG_START_SECOND; i++) begin
      wr_en    <= 1'b1;
      wr_index <= 3'(i);
      wr_data  <= start_words[i];
      @(posedge clk);
    end
    // unused register slot, must leave everything alone
    if ($urandom_range(0, 1) == 1) begin
      wr_en    <= 1'b1;
      wr_index <= CFG_START_SECOND + 3'($urandom_range(1, 2));
      wr_data  <= 16'($urandom);
      @(posedge clk);
    end
    wr_en <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int stall;
    result_ch.ready = 1'b0;
    forever begin
      stall = idle_draw();
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
    end
  end

  initial begin
    int          r;
    logic [2:0]  op;
    logic [15:0] amt;
    item_ch.valid  = 1'b0;
    item_ch.mode   = MODE_RESTART;
    item_ch.amount = '0;
    foreach (start_words[i]) start_words[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // start values straight from reset: 1 jan of year 0, midnight
    send_request(MODE_SECONDS, 16'd32767);
    send_request(MODE_MINUTES, 16'd32767);
    send_request(MODE_HOURS, 16'd32767);
    send_request(MODE_DAYS, 16'd32767);
    send_request(MODE_MONTHS, 16'd32767);
    send_request(MODE_YEARS, 16'd32767);
    send_request(MODE_SECONDS, 16'hFFFF);
    send_request(MODE_DAYS, 16'hFFFF);
    send_request(MODE_YEARS, 16'h8000);
    send_request(MODE_SPARE, 16'hFFFF);
    send_request(MODE_RESTART, 16'h8000);
    send_request(MODE_YEARS, 16'd32767);
    send_request(MODE_YEARS, 16'd32767);
    send_request(MODE_DAYS, 16'd32767);
    send_request(MODE_MONTHS, 16'd1);
    settle();

    // leap day at the last second of the day
    start_words[CFG_START_DAY]    = 16'd29;
    start_words[CFG_START_MONTH]  = 16'd2;
    start_words[CFG_START_YEAR]   = 16'd2000;
    start_words[CFG_START_HOUR]   = 16'd23;
    start_words[CFG_START_MINUTE] = 16'd59;
    start_words[CFG_START_SECOND] = 16'd59;
    load_start();
    send_request(MODE_RESTART, 16'd0);
    send_request(MODE_SECONDS, 16'd1);
    send_request(MODE_RESTART, 16'd0);
    send_request(MODE_YEARS, 16'd1);
    send_request(MODE_MINUTES, 16'd0);
    send_request(MODE_RESTART, 16'd0);
    send_request(MODE_YEARS, 16'd100);
    settle();

    // out-of-range start values with junk above the narrow fields, top year
    start_words[CFG_START_DAY]    = 16'hFFE0;
    start_words[CFG_START_MONTH]  = 16'hFFFF;
    start_words[CFG_START_YEAR]   = 16'hFFFF;
    start_words[CFG_START_HOUR]   = 16'hFFFF;
    start_words[CFG_START_MINUTE] = 16'hFFFF;
    start_words[CFG_START_SECOND] = 16'hFFFF;
    load_start();
    send_request(MODE_RESTART, 16'd0);
    send_request(MODE_MONTHS, 16'd0);
    send_request(MODE_SECONDS, 16'd1);
    send_request(MODE_DAYS, 16'd40);
    settle();

    // day that does not fit its month, non-leap century
    start_words[CFG_START_DAY]    = 16'd31;
    start_words[CFG_START_MONTH]  = 16'd4;
    start_words[CFG_START_YEAR]   = 16'd1900;
    start_words[CFG_START_HOUR]   = 16'd0;
    start_words[CFG_START_MINUTE] = 16'd0;
    start_words[CFG_START_SECOND] = 16'd0;
    load_start();
    send_request(MODE_RESTART, 16'd0);
    send_request(MODE_DAYS, 16'd0);
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0: begin
          start_words[CFG_START_DAY]    = 16'd1;
          start_words[CFG_START_MONTH]  = 16'd1;
          start_words[CFG_START_YEAR]   = 16'd0;
          start_words[CFG_START_HOUR]   = 16'd0;
          start_words[CFG_START_MINUTE] = 16'd0;
          start_words[CFG_START_SECOND] = 16'd0;
        end
        1: begin
          start_words[CFG_START_DAY]    = 16'd31;
          start_words[CFG_START_MONTH]  = 16'd12;
          start_words[CFG_START_YEAR]   = 16'hFFFF;
          start_words[CFG_START_HOUR]   = 16'd23;
          start_words[CFG_START_MINUTE] = 16'd59;
          start_words[CFG_START_SECOND] = 16'd59;
        end
        2: begin
          start_words[CFG_START_DAY] = ($urandom_range(0, 1) == 1) ?
                                       16'($urandom_range(28, 31)) : 16'($urandom_range(1, 31));
          start_words[CFG_START_MONTH] = ($urandom_range(0, 1) == 1) ?
                                         16'd2 : 16'($urandom_range(1, 12));
          case ($urandom_range(0, 3))
            0: start_words[CFG_START_YEAR] = 16'($urandom_range(0, 24) * 100);
            1: start_words[CFG_START_YEAR] = 16'($urandom_range(65000, 65535));
            default: start_words[CFG_START_YEAR] = 16'($urandom_range(1, 4000));
          endcase
          start_words[CFG_START_HOUR]   = 16'($urandom_range(0, 23));
          start_words[CFG_START_MINUTE] = 16'($urandom_range(0, 59));
          start_words[CFG_START_SECOND] = 16'($urandom_range(0, 59));
        end
        default: begin
          foreach (start_words[i]) start_words[i] = 16'($urandom);
        end
      endcase
      load_start();
      send_request(MODE_RESTART, 16'($urandom));
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 4) op = MODE_RESTART;
        else if (r < 7) op = MODE_SPARE;
        else op = 3'($urandom_range(MODE_SECONDS, MODE_YEARS));
        r = $urandom_range(0, 99);
        if (r < 8) amt = {1'b1, 15'($urandom)};
        else if (r < 55) amt = 16'($urandom_range(0, 70));
        else if (r < 85) amt = 16'($urandom_range(0, 2000));
        else if (op == MODE_YEARS && r < 97) amt = 16'($urandom_range(0, 500));
        else amt = {1'b0, 15'($urandom)};
        send_request(op, amt);
      end
      settle();
    end

    repeat (20) @(posedge clk);
    if (failures == 0 && backlog == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
